>>> rtl/ipv4hc_pkg.sv
// Package for the IPv4 header checker: verdict codes, register indexes,
// header constants and the snapshot record passed to the verdict stage.
// Depends on nothing; used by ipv4_header_checker.
package ipv4hc_pkg;

   localparam int DataWidth = 8;
   localparam int CountWidth = 16;
   localparam int SumWidth = 16;
   localparam int AddrWidth = 32;
   localparam int HlenWidth = 6;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth = 32;

   localparam logic [CountWidth-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic [CountWidth-1:0] MIN_HEADER_BYTES = 16'd20;
   localparam logic [3:0] IPV4_VERSION = 4'd4;
   localparam logic [3:0] MIN_IHL = 4'd5;
   localparam logic [3:0] IHL_MASK = 4'hF;
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [SumWidth-1:0] SUM_GOOD = 16'hFFFF;

   // Header byte positions of the captured fields.
   localparam logic [CountWidth-1:0] POS_VERSION_IHL = 16'd0;
   localparam logic [CountWidth-1:0] POS_TLEN_HIGH = 16'd2;
   localparam logic [CountWidth-1:0] POS_TLEN_LOW = 16'd3;
   localparam logic [CountWidth-1:0] POS_PROTOCOL = 16'd9;
   localparam logic [CountWidth-1:0] POS_SOURCE_FIRST = 16'd12;
   localparam logic [CountWidth-1:0] POS_SOURCE_LAST = 16'd15;
   localparam logic [CountWidth-1:0] POS_DEST_FIRST = 16'd16;
   localparam logic [CountWidth-1:0] POS_DEST_LAST = 16'd19;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LOCAL_ADDRESS     = 1'd0,
      CSR_DEST_CHECK_ENABLE = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_ACCEPT      = 3'd0,
      STATUS_SHORT       = 3'd1,
      STATUS_BAD_VERSION = 3'd2,
      STATUS_BAD_LENGTH  = 3'd3,
      STATUS_BAD_SUM     = 3'd4,
      STATUS_DEST_MISS   = 3'd5
   } status_type;

   // Packet state as it stands after the final byte has been folded in.
   typedef struct packed {
      logic [CountWidth-1:0] length;
      logic [7:0]            version_ihl;
      logic [15:0]           total_length;
      logic [7:0]            protocol;
      logic [AddrWidth-1:0]  source;
      logic [AddrWidth-1:0]  destination;
      logic [SumWidth-1:0]   word_sum;
   } snapshot_type;

endpackage

>>> rtl/ipv4_header_checker.sv
// IPv4 receive-header checker: byte-serial header capture, checksum fold and
// a verdict per packet. Depends on ipv4hc_pkg.
//
//  channel | direction | handshake                 | payload
//  req     | in        | req_valid / req_stall     | data_byte, last_byte
//  rsp     | out       | rsp_valid / rsp_stall     | status, protocol, source_address,
//          |           |                           | payload_length, header_length, is_icmp
//  csr     | in        | csr_write_enable          | csr_index, csr_write_data
//
// One byte is taken every cycle while the input is not stalled. The final byte of a
// packet moves the packet state into a snapshot register and clears the per-packet
// state in the same edge, so the next packet may start on the following cycle. The
// verdict is computed from the snapshot and registered in the result register once
// that register is free. Reset is synchronous and clears the packet state and both
// valid flags. A stalled result holds; the input stalls only when both the snapshot
// and the result register are full and the result is not being taken.
module ipv4_header_checker
   import ipv4hc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [DataWidth-1:0]     req_data_byte,
   input  logic                     req_last_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [7:0]               rsp_protocol,
   output logic [AddrWidth-1:0]     rsp_source_address,
   output logic [15:0]              rsp_payload_length,
   output logic [HlenWidth-1:0]     rsp_header_length,
   output logic                     rsp_is_icmp,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   // Configuration.
   logic [AddrWidth-1:0] local_address_ff;
   logic                 dest_check_enable_ff;

   // Per-packet state.
   logic [CountWidth-1:0] byte_count_ff, byte_count_in;
   logic [SumWidth-1:0]   word_sum_ff, word_sum_in;
   logic [7:0]            high_byte_hold_ff, high_byte_hold_in;
   logic [7:0]            version_ihl_ff, version_ihl_in;
   logic [15:0]           total_length_ff, total_length_in;
   logic [7:0]            protocol_ff, protocol_in;
   logic [AddrWidth-1:0]  source_ff, source_in;
   logic [AddrWidth-1:0]  destination_ff, destination_in;

   // Snapshot and result stages.
   logic         snap_valid_ff;
   snapshot_type snap_ff, snap_in;
   logic         rsp_valid_ff;
   status_type   status_ff, status_in;
   logic [7:0]           protocol_out_ff;
   logic [AddrWidth-1:0] source_out_ff;
   logic [15:0]          payload_length_ff, payload_length_in;
   logic [HlenWidth-1:0] header_length_ff, header_length_in;
   logic                 is_icmp_ff, is_icmp_in;

   logic req_accept;
   logic snap_advance;
   logic snap_free;
   logic rsp_load;

   logic [CountWidth-1:0] pos;
   logic [HlenWidth-1:0]  hlen_cur;
   logic [SumWidth:0]     sum_wide;

   logic [3:0]            snap_version;
   logic [3:0]            snap_ihl;
   logic [HlenWidth-1:0]  snap_hlen;
   logic [CountWidth-1:0] snap_hlen_wide;

   // Flow control.
   assign rsp_load     = !rsp_valid_ff || !rsp_stall;
   assign snap_advance = snap_valid_ff && rsp_load;
   assign snap_free    = !snap_valid_ff || snap_advance;
   assign req_stall    = !snap_free;
   assign req_accept   = req_valid && snap_free;

   // Byte intake: header capture and checksum fold.
   always_comb begin
      pos               = byte_count_ff;
      byte_count_in     = byte_count_ff;
      word_sum_in       = word_sum_ff;
      high_byte_hold_in = high_byte_hold_ff;
      version_ihl_in    = version_ihl_ff;
      total_length_in   = total_length_ff;
      protocol_in       = protocol_ff;
      source_in         = source_ff;
      destination_in    = destination_ff;
      sum_wide          = '0;
      hlen_cur          = '0;

      // Once the count saturates, further bytes change nothing.
      if (pos != COUNT_MAX) begin
         byte_count_in = pos + 16'd1;
         if (pos == POS_VERSION_IHL) begin
            version_ihl_in = req_data_byte;
         end else if (pos == POS_TLEN_HIGH) begin
            total_length_in = {req_data_byte, total_length_ff[7:0]};
         end else if (pos == POS_TLEN_LOW) begin
            total_length_in = {total_length_ff[15:8], req_data_byte};
         end else if (pos == POS_PROTOCOL) begin
            protocol_in = req_data_byte;
         end else if (pos >= POS_SOURCE_FIRST && pos <= POS_SOURCE_LAST) begin
            source_in = {source_ff[AddrWidth-9:0], req_data_byte};
         end else if (pos >= POS_DEST_FIRST && pos <= POS_DEST_LAST) begin
            destination_in = {destination_ff[AddrWidth-9:0], req_data_byte};
         end

         hlen_cur = {version_ihl_in[3:0] & IHL_MASK, 2'b00};
         if (!pos[0]) begin
            high_byte_hold_in = req_data_byte;
         end else if (pos < {{(CountWidth-HlenWidth){1'b0}}, hlen_cur}) begin
            // The running sum never exceeds 0xFFFF, so one end-around carry suffices.
            sum_wide    = {1'b0, word_sum_ff} + {1'b0, high_byte_hold_ff, req_data_byte};
            word_sum_in = sum_wide[SumWidth-1:0] + {{(SumWidth-1){1'b0}}, sum_wide[SumWidth]};
         end
      end

      snap_in.length       = byte_count_in;
      snap_in.version_ihl  = version_ihl_in;
      snap_in.total_length = total_length_in;
      snap_in.protocol     = protocol_in;
      snap_in.source       = source_in;
      snap_in.destination  = destination_in;
      snap_in.word_sum     = word_sum_in;
   end

   // Verdict from the snapshot.
   assign snap_version   = snap_ff.version_ihl[7:4];
   assign snap_ihl       = snap_ff.version_ihl[3:0] & IHL_MASK;
   assign snap_hlen      = {snap_ihl, 2'b00};
   assign snap_hlen_wide = {{(CountWidth-HlenWidth){1'b0}}, snap_hlen};

   always_comb begin
      if (snap_ff.length < MIN_HEADER_BYTES) begin
         status_in = STATUS_SHORT;
      end else if (snap_version != IPV4_VERSION || snap_ihl < MIN_IHL
                   || snap_hlen_wide > snap_ff.length) begin
         status_in = STATUS_BAD_VERSION;
      end else if (snap_ff.total_length < snap_hlen_wide
                   || snap_ff.total_length > snap_ff.length) begin
         status_in = STATUS_BAD_LENGTH;
      end else if (snap_ff.word_sum != SUM_GOOD) begin
         status_in = STATUS_BAD_SUM;
      end else if (dest_check_enable_ff && snap_ff.destination != local_address_ff) begin
         status_in = STATUS_DEST_MISS;
      end else begin
         status_in = STATUS_ACCEPT;
      end

      header_length_in  = snap_hlen;
      payload_length_in = '0;
      is_icmp_in        = 1'b0;
      if (status_in == STATUS_ACCEPT) begin
         payload_length_in = snap_ff.total_length - snap_hlen_wide;
         is_icmp_in        = (snap_ff.protocol == PROTO_ICMP);
      end
   end

   // Control and packet state.
   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff     <= '0;
         dest_check_enable_ff <= 1'b1;
         byte_count_ff        <= '0;
         word_sum_ff          <= '0;
         high_byte_hold_ff    <= '0;
         version_ihl_ff       <= '0;
         total_length_ff      <= '0;
         protocol_ff          <= '0;
         source_ff            <= '0;
         destination_ff       <= '0;
         snap_valid_ff        <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LOCAL_ADDRESS:     local_address_ff <= csr_write_data[AddrWidth-1:0];
               CSR_DEST_CHECK_ENABLE: dest_check_enable_ff <= csr_write_data[0];
               default: ;
            endcase
         end

         if (req_accept) begin
            if (req_last_byte) begin
               byte_count_ff     <= '0;
               word_sum_ff       <= '0;
               high_byte_hold_ff <= '0;
               version_ihl_ff    <= '0;
               total_length_ff   <= '0;
               protocol_ff       <= '0;
               source_ff         <= '0;
               destination_ff    <= '0;
            end else begin
               byte_count_ff     <= byte_count_in;
               word_sum_ff       <= word_sum_in;
               high_byte_hold_ff <= high_byte_hold_in;
               version_ihl_ff    <= version_ihl_in;
               total_length_ff   <= total_length_in;
               protocol_ff       <= protocol_in;
               source_ff         <= source_in;
               destination_ff    <= destination_in;
            end
         end

         if (req_accept && req_last_byte) begin
            snap_valid_ff <= 1'b1;
         end else if (snap_advance) begin
            snap_valid_ff <= 1'b0;
         end

         if (rsp_load) begin
            rsp_valid_ff <= snap_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept && req_last_byte) begin
         snap_ff <= snap_in;
      end
      if (snap_advance) begin
         status_ff         <= status_in;
         protocol_out_ff   <= snap_ff.protocol;
         source_out_ff     <= snap_ff.source;
         payload_length_ff <= payload_length_in;
         header_length_ff  <= header_length_in;
         is_icmp_ff        <= is_icmp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_protocol       = protocol_out_ff;
   assign rsp_source_address = source_out_ff;
   assign rsp_payload_length = payload_length_ff;
   assign rsp_header_length  = header_length_ff;
   assign rsp_is_icmp        = is_icmp_ff;

endmodule

>>> tb/ipv4_header_checker_tb.sv
// Self-checking testbench for ipv4_header_checker: drives byte-serial packets,
// predicts each verdict in a scoreboard class and checks every result item.
// Depends on ipv4hc_pkg and the ipv4_header_checker RTL.
`timescale 1ns / 1ps

module ipv4_header_checker_tb;
   import ipv4hc_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   typedef struct packed {
      status_type           status;
      logic [7:0]           protocol;
      logic [AddrWidth-1:0] source;
      logic [15:0]          payload_length;
      logic [HlenWidth-1:0] header_length;
      logic                 is_icmp;
   } verdict_type;

   // Tracks the packet state byte by byte and holds the verdicts still owed.
   class verdict_scoreboard_type;
      logic [31:0] local_addr;
      logic        dest_check;
      logic [15:0] byte_count;
      logic [16:0] word_fold;
      logic [7:0]  high_hold;
      logic [7:0]  version_ihl;
      logic [15:0] tlen_field;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] dest;
      verdict_type pending[$];
      int          checked;
      int          failures;
      int          status_seen[6];

      function new();
         local_addr = '0;
         dest_check = 1'b1;
         clear_packet();
      endfunction

      function void clear_packet();
         byte_count = '0;
         word_fold = '0;
         high_hold = '0;
         version_ihl = '0;
         tlen_field = '0;
         protocol = '0;
         source = '0;
         dest = '0;
      endfunction

      function void note_byte(logic [7:0] data, logic last);
         int unsigned pos;
         int unsigned hlen;
         int unsigned tlen;
         int unsigned length;
         verdict_type v;
         pos = 32'(byte_count);
         // Past the saturation point a byte neither counts nor changes anything.
         if (pos < COUNT_MAX) begin
            if (pos == POS_VERSION_IHL) version_ihl = data;
            else if (pos == POS_TLEN_HIGH) tlen_field[15:8] = data;
            else if (pos == POS_TLEN_LOW) tlen_field[7:0] = data;
            else if (pos == POS_PROTOCOL) protocol = data;
            else if (pos >= POS_SOURCE_FIRST && pos <= POS_SOURCE_LAST)
               source = {source[23:0], data};
            else if (pos >= POS_DEST_FIRST && pos <= POS_DEST_LAST)
               dest = {dest[23:0], data};
            hlen = int'(version_ihl[3:0]) * 4;
            if (pos % 2 == 0) begin
               high_hold = data;
            end else if (pos < hlen) begin
               word_fold = word_fold + {1'b0, high_hold, data};
               word_fold = {1'b0, word_fold[15:0]} + {16'd0, word_fold[16]};
            end
            byte_count = 16'(pos + 1);
         end
         if (!last) return;

         length = 32'(byte_count);
         hlen = int'(version_ihl[3:0]) * 4;
         tlen = 32'(tlen_field);
         if (length < MIN_HEADER_BYTES)
            v.status = STATUS_SHORT;
         else if (version_ihl[7:4] != IPV4_VERSION || version_ihl[3:0] < MIN_IHL
                  || hlen > length)
            v.status = STATUS_BAD_VERSION;
         else if (tlen < hlen || tlen > length)
            v.status = STATUS_BAD_LENGTH;
         else if (word_fold != {1'b0, SUM_GOOD})
            v.status = STATUS_BAD_SUM;
         else if (dest_check && dest != local_addr)
            v.status = STATUS_DEST_MISS;
         else
            v.status = STATUS_ACCEPT;
         v.protocol = protocol;
         v.source = source;
         v.payload_length = (v.status == STATUS_ACCEPT) ? 16'(tlen - hlen) : 16'd0;
         v.header_length = hlen[5:0];
         v.is_icmp = (v.status == STATUS_ACCEPT && protocol == PROTO_ICMP);
         pending.push_back(v);
         status_seen[v.status]++;
         clear_packet();
      endfunction

      function void check_result(verdict_type got);
         verdict_type want;
         checked++;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("Unexpected verdict: status %0d protocol %02h source %08h",
                        got.status, got.protocol, got.source);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.protocol !== want.protocol
             || got.source !== want.source || got.payload_length !== want.payload_length
             || got.header_length !== want.header_length || got.is_icmp !== want.is_icmp)
         begin
            failures++;
            if (failures <= 10) begin
               $display({"Verdict %0d mismatch, expected: status %0d protocol %02h ",
                         "source %08h payload %0d hlen %0d icmp %0d"},
                        checked, want.status, want.protocol, want.source,
                        want.payload_length, want.header_length, want.is_icmp);
               $display({"  actual: status %0d protocol %02h source %08h ",
                         "payload %0d hlen %0d icmp %0d"},
                        got.status, got.protocol, got.source,
                        got.payload_length, got.header_length, got.is_icmp);
            end
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [DataWidth-1:0]     req_data_byte;
   logic                     req_last_byte;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [2:0]               rsp_status;
   logic [7:0]               rsp_protocol;
   logic [AddrWidth-1:0]     rsp_source_address;
   logic [15:0]              rsp_payload_length;
   logic [HlenWidth-1:0]     rsp_header_length;
   logic                     rsp_is_icmp;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;

   verdict_scoreboard_type sb;
   int req_idle_pct = 37;
   int rsp_idle_pct = 37;
   bit hold_request = 1'b0;
   int hold_cycles = 200;
   int bytes_sent = 0;
   int packets_sent = 0;
   int stall_cycles = 0;

   ipv4_header_checker dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_protocol       (rsp_protocol),
      .rsp_source_address (rsp_source_address),
      .rsp_payload_length (rsp_payload_length),
      .rsp_header_length  (rsp_header_length),
      .rsp_is_icmp        (rsp_is_icmp),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("ipv4_header_checker_tb failed");
      $finish;
   end

   // Everything the block sees or produces is sampled here, at the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LOCAL_ADDRESS:     sb.local_addr = csr_write_data;
               CSR_DEST_CHECK_ENABLE: sb.dest_check = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_stall) stall_cycles++;
         if (req_valid && !req_stall) sb.note_byte(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_result('{status: status_type'(rsp_status), protocol: rsp_protocol,
                              source: rsp_source_address,
                              payload_length: rsp_payload_length,
                              header_length: rsp_header_length, is_icmp: rsp_is_icmp});
      end
   end

   // Result side: random stalls, plus a long hold-off when one is requested.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_packet(input byte_queue_type pkt);
      for (int i = 0; i < pkt.size(); i++)
         send_byte(pkt[i], i == pkt.size() - 1);
      packets_sent++;
   endtask

   // Drops valid and waits until every verdict owed has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   task automatic write_regs(input logic [31:0] addr, input logic enable);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_LOCAL_ADDRESS;
      csr_write_data <= addr;
      @(posedge clock);
      csr_index <= CSR_DEST_CHECK_ENABLE;
      csr_write_data <= {31'd0, enable};
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Builds a header with a correct checksum over the first IHL*4 bytes,
   // followed by payload and padding bytes.
   function automatic void make_packet(output byte_queue_type pkt, input logic [3:0] version,
                                       input logic [3:0] ihl, input int payload_bytes,
                                       input int pad_bytes, input int tlen_delta,
                                       input logic [7:0] proto, input logic [31:0] dst);
      int          header_bytes;
      logic [15:0] tlen;
      logic [16:0] fold;
      header_bytes = (ihl < MIN_IHL) ? 20 : ihl * 4;
      tlen = 16'(header_bytes + payload_bytes + tlen_delta);
      pkt = {};
      for (int i = 0; i < header_bytes + payload_bytes + pad_bytes; i++)
         pkt.push_back(8'($urandom_range(255)));
      pkt[0] = {version, ihl};
      pkt[2] = tlen[15:8];
      pkt[3] = tlen[7:0];
      pkt[9] = proto;
      pkt[10] = 8'd0;
      pkt[11] = 8'd0;
      for (int i = 0; i < 4; i++) pkt[16 + i] = dst[31 - 8 * i -: 8];
      fold = '0;
      for (int i = 0; i + 1 < ihl * 4; i += 2) begin
         fold = fold + {1'b0, pkt[i], pkt[i + 1]};
         fold = {1'b0, fold[15:0]} + {16'd0, fold[16]};
      end
      pkt[10] = ~fold[15:8];
      pkt[11] = ~fold[7:0];
   endfunction

   task automatic send_random_packet();
      byte_queue_type pkt;
      int          kind;
      int          mode;
      logic [3:0]  version;
      logic [3:0]  ihl;
      int          tlen_delta;
      logic [7:0]  proto;
      logic [31:0] dst;
      kind = $urandom_range(99);
      mode = $urandom_range(4);
      version = IPV4_VERSION;
      ihl = ($urandom_range(4) == 0) ? 4'($urandom_range(15, 6)) : MIN_IHL;
      tlen_delta = 0;
      proto = ($urandom_range(3) == 0) ? PROTO_ICMP : 8'($urandom_range(255));
      dst = ($urandom_range(4) == 0) ? 32'($urandom) : sb.local_addr;
      if (kind >= 80) begin
         pkt = {};
         repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom_range(255)));
      end else begin
         if (kind >= 55) begin
            if (mode == 1) version = 4'(($urandom_range(14) + 5) % 16);
            if (mode == 2) ihl = 4'($urandom_range(4));
            if (mode == 3)
               tlen_delta = $urandom_range(1) ? $urandom_range(1, 8) : -$urandom_range(1, 30);
         end
         make_packet(pkt, version, ihl, $urandom_range(12),
                     ($urandom_range(4) == 0) ? $urandom_range(1, 4) : 0,
                     tlen_delta, proto, dst);
         if (kind >= 55 && mode == 0)
            pkt[$urandom_range(19)] ^= 8'h01 << $urandom_range(7);
         if (kind >= 55 && mode == 4)
            pkt = pkt[0:$urandom_range(pkt.size() - 2)];
      end
      send_packet(pkt);
   endtask

   task automatic run_random(input int min_bytes, input int min_packets);
      int bytes_start;
      int packets_start;
      bytes_start = bytes_sent;
      packets_start = packets_sent;
      while (bytes_sent - bytes_start < min_bytes || packets_sent - packets_start < min_packets)
         send_random_packet();
   endtask

   initial begin
      byte_queue_type pkt;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_LOCAL_ADDRESS;
      csr_write_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed packets with the local address at zero and the check on.
      write_regs(32'h0000_0000, 1'b1);
      pkt = {8'hFF};
      send_packet(pkt);
      make_packet(pkt, IPV4_VERSION, MIN_IHL, 0, 0, 0, 8'h06, 32'h0);
      pkt = pkt[0:18];
      send_packet(pkt);
      make_packet(pkt, IPV4_VERSION, MIN_IHL, 0, 0, 0, PROTO_ICMP, 32'h0);
      send_packet(pkt);
      make_packet(pkt, IPV4_VERSION, 4'd15, 0, 0, 0, 8'hFF, 32'h0);
      send_packet(pkt);
      make_packet(pkt, 4'd6, MIN_IHL, 4, 0, 0, 8'h11, 32'h0);
      send_packet(pkt);
      make_packet(pkt, 4'd0, 4'd0, 2, 0, 0, 8'h11, 32'h0);
      send_packet(pkt);
      make_packet(pkt, IPV4_VERSION, 4'd4, 2, 0, 0, 8'h11, 32'h0);
      send_packet(pkt);
      // The header claims 60 bytes but the packet ends at 40.
      make_packet(pkt, IPV4_VERSION, 4'd15, 0, 0, 0, 8'h11, 32'h0);
      pkt = pkt[0:39];
      send_packet(pkt);
      make_packet(pkt, IPV4_VERSION, MIN_IHL, 0, 0, -10, 8'h11, 32'h0);
      send_packet(pkt);
      make_packet(pkt, IPV4_VERSION, MIN_IHL, 3, 0, 1, 8'h11, 32'h0);
      send_packet(pkt);
      make_packet(pkt, IPV4_VERSION, MIN_IHL, 3, 0, 0, 8'h11, 32'h0);
      pkt[11] ^= 8'h01;
      send_packet(pkt);
      make_packet(pkt, IPV4_VERSION, MIN_IHL, 3, 0, 0, PROTO_ICMP, 32'hFFFF_FFFF);
      send_packet(pkt);
      make_packet(pkt, IPV4_VERSION, MIN_IHL, 5, 7, 0, PROTO_ICMP, 32'h0);
      send_packet(pkt);
      pkt = {};
      repeat (20) pkt.push_back(8'hFF);
      send_packet(pkt);
      pkt = {};
      repeat (20) pkt.push_back(8'h00);
      send_packet(pkt);

      write_regs(32'hFFFF_FFFF, 1'b1);
      run_random(24, 1);
      // Hold the result side off while single-byte packets keep coming.
      req_idle_pct = 0;
      hold_request = 1'b1;
      repeat (30) begin
         pkt = {8'($urandom_range(255))};
         send_packet(pkt);
      end
      req_idle_pct = 37;
      wait_drained();
      run_random(16, 1);

      write_regs(32'($urandom), 1'b0);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(40, 1);
      req_idle_pct = 37;
      rsp_idle_pct = 37;

      write_regs(32'($urandom), 1'b1);
      run_random(24, 1);

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Checked %0d verdicts from %0d bytes in %0d packets; input stalled %0d cycles.",
               sb.checked, bytes_sent, packets_sent, stall_cycles);
      $display({"Statuses seen: accept %0d, short %0d, version/IHL %0d, ",
                "length %0d, sum %0d, dest %0d"},
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
               sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
      if (sb.failures == 0 && sb.pending.size() == 0) begin
         $display("ipv4_header_checker_tb passed");
      end else begin
         $display("ipv4_header_checker_tb failed");
      end
      $finish;
   end

endmodule
